// ===== design/gtg_pkg.sv =====
// Shared types, constants and helper functions of the go-to-goal controller.
// Used by gtg_smul and go_to_goal_controller; depends on nothing else.
package gtg_pkg;

    localparam int MulW      = 52;   // product and multiplicand width
    localparam int MulBits   = 18;   // multiplier width, one bit retired per cycle
    localparam int CordW     = 28;   // CORDIC x/y datapath width
    localparam int AngTabLen = 24;
    localparam int OutW      = 24;

    localparam logic [MulBits-1:0] HeadScale = 18'd83443;   // Q3.13 rad to binary angle
    localparam logic [MulBits-1:0] ErrScale  = 18'd205887;  // binary angle to Q3.13 rad

    typedef enum logic [2:0] {
        CFG_GOAL_X    = 3'd0,
        CFG_GOAL_Y    = 3'd1,
        CFG_TOLERANCE = 3'd2,
        CFG_LIN_GAIN  = 3'd3,
        CFG_ANG_GAIN  = 3'd4,
        CFG_INT_GAIN  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic               start;
        logic [MulW-1:0]    multiplicand;
        logic [MulBits-1:0] multiplier;
    } t_mul_req;

    typedef struct packed {
        logic            done;
        logic [MulW-1:0] product;
    } t_mul_rsp;

    function automatic logic [31:0] cordic_angle(input logic [4:0] idx);
        logic [31:0] a;
        unique case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051D;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2E;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2F9;
            5'd15:   a = 32'h0000517C;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A2F;
            5'd19:   a = 32'h00000517;
            5'd20:   a = 32'h0000028B;
            5'd21:   a = 32'h00000145;
            5'd22:   a = 32'h000000A2;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

    // Clamp a signed wide value to the 24-bit command range.
    function automatic logic [OutW-1:0] sat24(input logic signed [MulW-1:0] v);
        logic [OutW-1:0] r;
        if (v > $signed(52'sd8388607)) begin
            r = 24'h7FFFFF;
        end else if (v < -$signed(52'sd8388608)) begin
            r = 24'h800000;
        end else begin
            r = v[OutW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/gtg_smul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on gtg_pkg for widths and the request/response structs.
module gtg_smul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gtg_pkg::t_mul_req i_req,
    output gtg_pkg::t_mul_rsp o_rsp
);
    import gtg_pkg::*;

    logic [MulW-1:0]    r_a;
    logic [MulBits-1:0] r_b;
    logic [MulW-1:0]    r_acc;
    logic [4:0]         r_cnt;
    logic               r_busy;
    logic               r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_a    <= i_req.multiplicand;
            r_b    <= i_req.multiplier;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_acc <= r_acc + (r_b[0] ? r_a : '0);
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(MulBits - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

endmodule

// ===== design/go_to_goal_controller.sv =====
// Go-to-goal controller: distance, bearing and velocity commands for a planar robot.
// Depends on gtg_pkg and instantiates the serial multiplier gtg_smul.
//
// One pose word in gives one command word out. From acceptance until the command word is
// valid an item takes seven passes through the single bit-serial multiplier (two squares,
// heading scale, error scale, angular gain, two linear terms), a digit-by-digit square
// root, one CORDIC step per cycle for CORDIC_ITERATIONS steps (at most 24) and the load
// of the output register, which waits while a stalled word still holds it. The next pose
// is taken in the cycle after that load. Once the goal is reached the word is answered
// with zero commands and the arrived flag. A new pose is taken while the previous result
// still waits at the output. Writing the goal or the tolerance clears the integrator and
// the arrived flag; gain writes take effect at once.
module go_to_goal_controller #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_pose_x,
    input  logic [15:0] i_pose_y,
    input  logic [15:0] i_pose_heading,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_linear_velocity,
    output logic [23:0] o_angular_velocity,
    output logic        o_arrived,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import gtg_pkg::*;

    localparam int CordN = (CORDIC_ITERATIONS > AngTabLen) ? AngTabLen : CORDIC_ITERATIONS;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_SQX  = 11'b00000000010,
        ST_SQY  = 11'b00000000100,
        ST_SQRT = 11'b00000001000,
        ST_CORD = 11'b00000010000,
        ST_HEAD = 11'b00000100000,
        ST_ERR  = 11'b00001000000,
        ST_ANG  = 11'b00010000000,
        ST_LINA = 11'b00100000000,
        ST_LINB = 11'b01000000000,
        ST_DONE = 11'b10000000000
    } t_state;

    t_state r_state;

    logic [15:0] r_goal_x, r_goal_y, r_tol, r_lin_gain, r_ang_gain, r_int_gain;
    logic [31:0] r_integ;
    logic        r_arrived;

    logic signed [16:0] r_dx, r_dy;
    logic [15:0]        r_head;
    logic [MulW-1:0]    r_sq;
    logic [33:0]        r_rem, r_res, r_bit;
    logic [16:0]        r_dist;
    logic signed [CordW-1:0] r_cx, r_cy;
    logic [31:0]        r_cz;
    logic [4:0]         r_iter;
    logic [MulW-1:0]    r_lin_hi;
    logic [OutW-1:0]    r_ang_res, r_lin_res;
    logic               r_arr_res;

    logic            r_out_valid;
    logic [OutW-1:0] r_out_lin, r_out_ang;
    logic            r_out_arr;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    gtg_smul u_smul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_rsp  (mul_rsp)
    );

    logic               in_accept;
    logic signed [16:0] dx_in, dy_in;
    logic [16:0]        dx_in_abs, dy_abs;

    assign in_accept = i_valid && !o_stall;
    assign dx_in     = {r_goal_x[15], r_goal_x} - {i_pose_x[15], i_pose_x};
    assign dy_in     = {r_goal_y[15], r_goal_y} - {i_pose_y[15], i_pose_y};
    assign dx_in_abs = dx_in[16] ? 17'(-dx_in) : 17'(dx_in);
    assign dy_abs    = r_dy[16] ? 17'(-r_dy) : 17'(r_dy);

    // Square root: one result bit per cycle.
    logic [33:0] sq_trial, n_rem, n_res;
    logic        sq_ge;
    assign sq_trial = r_res + r_bit;
    assign sq_ge    = r_rem >= sq_trial;
    assign n_rem    = sq_ge ? r_rem - sq_trial : r_rem;
    assign n_res    = sq_ge ? (r_res >> 1) + r_bit : r_res >> 1;

    logic [16:0] n_dist;
    logic        at_goal;
    logic [32:0] integ_sum;
    assign n_dist    = n_res[16:0];
    assign at_goal   = n_dist <= {1'b0, r_tol};
    assign integ_sum = {1'b0, r_integ} + 33'(n_dist);

    // CORDIC pre-rotation and step.
    logic signed [CordW-1:0] cx_init, cy_init, cx_sh, cy_sh, n_cx, n_cy;
    logic [31:0]             n_cz;
    logic                    cy_pos, cord_last;
    assign cx_init   = CordW'(r_dx) <<< 8;
    assign cy_init   = CordW'(r_dy) <<< 8;
    assign cx_sh     = r_cx >>> r_iter;
    assign cy_sh     = r_cy >>> r_iter;
    assign cy_pos    = !r_cy[CordW-1] && (r_cy != '0);
    assign n_cx      = cy_pos ? r_cx + cy_sh : r_cx - cy_sh;
    assign n_cy      = cy_pos ? r_cy - cx_sh : r_cy + cx_sh;
    assign n_cz      = cy_pos ? r_cz + cordic_angle(r_iter) : r_cz - cordic_angle(r_iter);
    assign cord_last = r_iter == 5'(CordN - 1);

    // Post-processing of multiplier results.
    logic signed [MulW-1:0] prod_s, errq_sum, ang_sum, lin_sum;
    logic [31:0]            err_now;
    logic signed [17:0]     errq_now;
    assign prod_s   = $signed(mul_rsp.product);
    assign err_now  = r_cz - mul_rsp.product[31:0];
    assign errq_sum = prod_s + $signed(MulW'(64'd1 << 33));
    assign errq_now = errq_sum[MulW-1:34];
    assign ang_sum  = (prod_s + $signed(MulW'(512))) >>> 10;
    assign lin_sum  = $signed((r_lin_hi + mul_rsp.product + MulW'(64'd1 << 23)) >> 24);

    always_comb begin
        mul_req = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && !r_arrived) begin
                    mul_req.start        = 1'b1;
                    mul_req.multiplicand = MulW'(dx_in_abs);
                    mul_req.multiplier   = MulBits'(dx_in_abs);
                end
            end
            ST_SQX: begin
                if (mul_rsp.done) begin
                    mul_req.start        = 1'b1;
                    mul_req.multiplicand = MulW'(dy_abs);
                    mul_req.multiplier   = MulBits'(dy_abs);
                end
            end
            ST_CORD: begin
                if (cord_last) begin
                    mul_req.start        = 1'b1;
                    mul_req.multiplicand = MulW'($signed(r_head));
                    mul_req.multiplier   = HeadScale;
                end
            end
            ST_HEAD: begin
                if (mul_rsp.done) begin
                    mul_req.start        = 1'b1;
                    mul_req.multiplicand = MulW'($signed(err_now));
                    mul_req.multiplier   = ErrScale;
                end
            end
            ST_ERR: begin
                if (mul_rsp.done) begin
                    mul_req.start        = 1'b1;
                    mul_req.multiplicand = MulW'(errq_now);
                    mul_req.multiplier   = MulBits'(r_ang_gain);
                end
            end
            ST_ANG: begin
                if (mul_rsp.done) begin
                    mul_req.start        = 1'b1;
                    mul_req.multiplicand = MulW'(r_dist);
                    mul_req.multiplier   = MulBits'(r_lin_gain);
                end
            end
            ST_LINA: begin
                if (mul_rsp.done) begin
                    mul_req.start        = 1'b1;
                    mul_req.multiplicand = MulW'(r_integ);
                    mul_req.multiplier   = MulBits'(r_int_gain);
                end
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_tol       <= 16'd512;
            r_lin_gain  <= 16'd512;
            r_ang_gain  <= 16'd1536;
            r_int_gain  <= 16'd3355;
            r_integ     <= '0;
            r_arrived   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_GOAL_X: begin
                        r_goal_x  <= i_cfg_data;
                        r_integ   <= '0;
                        r_arrived <= 1'b0;
                    end
                    CFG_GOAL_Y: begin
                        r_goal_y  <= i_cfg_data;
                        r_integ   <= '0;
                        r_arrived <= 1'b0;
                    end
                    CFG_TOLERANCE: begin
                        r_tol     <= i_cfg_data;
                        r_integ   <= '0;
                        r_arrived <= 1'b0;
                    end
                    CFG_LIN_GAIN: r_lin_gain <= i_cfg_data;
                    CFG_ANG_GAIN: r_ang_gain <= i_cfg_data;
                    CFG_INT_GAIN: r_int_gain <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_dx   <= dx_in;
                        r_dy   <= dy_in;
                        r_head <= i_pose_heading;
                        if (r_arrived) begin
                            r_lin_res <= '0;
                            r_ang_res <= '0;
                            r_arr_res <= 1'b1;
                            r_state   <= ST_DONE;
                        end else begin
                            r_state <= ST_SQX;
                        end
                    end
                end
                ST_SQX: begin
                    if (mul_rsp.done) begin
                        r_sq    <= mul_rsp.product;
                        r_state <= ST_SQY;
                    end
                end
                ST_SQY: begin
                    if (mul_rsp.done) begin
                        r_rem   <= 34'(r_sq + mul_rsp.product);
                        r_res   <= '0;
                        r_bit   <= 34'd1 << 32;
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_rem <= n_rem;
                    r_res <= n_res;
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_dist <= n_dist;
                        if (at_goal) begin
                            r_arrived <= 1'b1;
                            r_lin_res <= '0;
                            r_ang_res <= '0;
                            r_arr_res <= 1'b1;
                            r_state   <= ST_DONE;
                        end else begin
                            r_integ <= integ_sum[32] ? 32'hFFFFFFFF : integ_sum[31:0];
                            r_iter  <= '0;
                            if (r_dx[16]) begin
                                r_cx <= -cx_init;
                                r_cy <= -cy_init;
                                r_cz <= 32'h80000000;
                            end else begin
                                r_cx <= cx_init;
                                r_cy <= cy_init;
                                r_cz <= '0;
                            end
                            r_state <= ST_CORD;
                        end
                    end
                end
                ST_CORD: begin
                    r_cx   <= n_cx;
                    r_cy   <= n_cy;
                    r_cz   <= n_cz;
                    r_iter <= r_iter + 5'd1;
                    if (cord_last) begin
                        r_state <= ST_HEAD;
                    end
                end
                ST_HEAD: begin
                    if (mul_rsp.done) begin
                        r_state <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    if (mul_rsp.done) begin
                        r_state <= ST_ANG;
                    end
                end
                ST_ANG: begin
                    if (mul_rsp.done) begin
                        r_ang_res <= sat24(ang_sum);
                        r_state   <= ST_LINA;
                    end
                end
                ST_LINA: begin
                    if (mul_rsp.done) begin
                        r_lin_hi <= mul_rsp.product << 16;
                        r_state  <= ST_LINB;
                    end
                end
                ST_LINB: begin
                    if (mul_rsp.done) begin
                        r_lin_res <= sat24(lin_sum);
                        r_arr_res <= 1'b0;
                        r_state   <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // The word moves to the output register once that is free.
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_lin   <= r_lin_res;
                        r_out_ang   <= r_ang_res;
                        r_out_arr   <= r_arr_res;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall            = r_state != ST_IDLE;
    assign o_cfg_ready        = 1'b1;
    assign o_valid            = r_out_valid;
    assign o_linear_velocity  = r_out_lin;
    assign o_angular_velocity = r_out_ang;
    assign o_arrived          = r_out_arr;

    a_arrived_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_arrived |-> o_linear_velocity == '0 && o_angular_velocity == '0)
        else $error("arrived word carries non-zero commands");

    a_linear_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_linear_velocity[OutW-1])
        else $error("linear command negative");

    a_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> r_state == ST_SQX || r_state == ST_SQY || r_state == ST_HEAD
            || r_state == ST_ERR || r_state == ST_ANG || r_state == ST_LINA
            || r_state == ST_LINB)
        else $error("multiplier finished outside a multiply step");

endmodule
